### design/cps_pkg.sv
// Shared types and fixed constants of the circular point smoother.
package cps_pkg;

  localparam int COORD_W = 20;
  localparam int PASS_W = 4;
  localparam logic [PASS_W-1:0] PASSES_RESET = 4'd1;

  // Register stages from a sum entering the divider to its quotient.
  localparam int DIV_LAT = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

endpackage

### design/cps_store.sv
// Point store: one write port and one registered read port.
module cps_store #(
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  cps_pkg::point_t       wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output cps_pkg::point_t       rdata
);
  import cps_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/cps_rdiv.sv
// Pipelined divide of a signed window sum by the window span, rounding to nearest.
module cps_rdiv #(
  parameter int SPAN = 5,
  parameter int SUM_W = 24
) (
  input  logic                    clk,
  input  logic signed [SUM_W-1:0] sum,
  output cps_pkg::coord_t         quot
);
  import cps_pkg::*;

  localparam int MAG_W = SUM_W;
  // floor(2^MAG_W / SPAN); the product estimate is low by at most one.
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / SPAN);
  localparam logic [MAG_W-1:0] HALF = MAG_W'(SPAN / 2);
  localparam logic [MAG_W-1:0] SPAN_V = MAG_W'(SPAN);

  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   s1_madd;
  logic               s1_neg;
  logic [2*MAG_W-1:0] prod;
  logic [MAG_W-1:0]   s2_q0;
  logic [MAG_W-1:0]   s2_madd;
  logic               s2_neg;
  logic [MAG_W-1:0]   rem;
  logic [MAG_W-1:0]   q_fix;
  logic [MAG_W-1:0]   q_signed;

  // Ties go away from zero, so round the magnitude and restore the sign.
  assign mag = sum[SUM_W-1] ? MAG_W'(~sum + 1'b1) : MAG_W'(sum);

  always_ff @(posedge clk) begin
    s1_madd <= mag + HALF;
    s1_neg <= sum[SUM_W-1];
  end

  assign prod = {{MAG_W{1'b0}}, s1_madd} * {{MAG_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    s2_q0 <= prod[2*MAG_W-1:MAG_W];
    s2_madd <= s1_madd;
    s2_neg <= s1_neg;
  end

  assign rem = s2_madd - MAG_W'(s2_q0 * SPAN_V);
  assign q_fix = (rem >= SPAN_V) ? s2_q0 + 1'b1 : s2_q0;
  assign q_signed = s2_neg ? ~q_fix + 1'b1 : q_fix;

  always_ff @(posedge clk) begin
    quot <= coord_t'(q_signed[COORD_W-1:0]);
  end

endmodule

### design/circular_point_smoother_top.sv
// Top level of the circular point smoother: load, smoothing sequencer and emit.
//
// Points are loaded one per cycle while in_ready is high; the beat with last_in set
// closes the contour and in_ready drops until the last result beat is taken. For a
// contour of N points (N at least WINDOW and passes nonzero) each pass handles each
// point in turn: SPAN reads, where SPAN = 2*(WINDOW/2)+1, through the single store
// read port into the x and y accumulators, a drain state for the read register, and
// the three-stage reciprocal divider shared by x and y. Emission then reads each
// point and holds it in S_EMIT_OUT until out_ready. The store needs no clearing
// after reset.
module circular_point_smoother_top #(
  parameter int MAX_POINTS = 64,
  parameter int WINDOW = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cps_pkg::coord_t         point_x,
  input  cps_pkg::coord_t         point_y,
  input  logic                    last_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cps_pkg::coord_t         smooth_x,
  output cps_pkg::coord_t         smooth_y,
  output logic                    last_out,
  output logic                    overflow
);
  import cps_pkg::*;

  localparam int HALF = WINDOW / 2;
  localparam int SPAN = 2 * HALF + 1;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int TAP_W = $clog2(SPAN);
  localparam int SUM_W = COORD_W + $clog2(SPAN) + 1;
  localparam logic [2:0] DIV_LAST = 3'(DIV_LAT + 1);

  typedef enum logic [5:0] {
    S_LOAD     = 6'b000001,
    S_READ     = 6'b000010,
    S_DRAIN    = 6'b000100,
    S_DIV      = 6'b001000,
    S_EMIT_RD  = 6'b010000,
    S_EMIT_OUT = 6'b100000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        point_count;
  logic                    dropped;
  logic [PASS_W-1:0]       passes;
  logic [PASS_W-1:0]       pass_cnt;
  logic [ADDR_W-1:0]       pt_idx;
  logic [ADDR_W-1:0]       win_start;
  logic [ADDR_W-1:0]       rd_ptr;
  logic [ADDR_W-1:0]       emit_idx;
  logic [TAP_W-1:0]        tap;
  logic [2:0]              dcnt;
  logic                    rd_vld;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  coord_t                  res_x;

  logic                    full;
  logic                    in_acc;
  logic [CNT_W-1:0]        n_after;
  logic [ADDR_W-1:0]       start_after;
  logic [ADDR_W-1:0]       start_now;
  logic [ADDR_W-1:0]       ws_next;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  point_t                  mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  point_t                  mem_rdata;
  logic signed [SUM_W-1:0] div_in;
  coord_t                  div_q;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0] n);
    logic [ADDR_W-1:0] r;
    r = (CNT_W'(a) + CNT_W'(1) == n) ? '0 : a + 1'b1;
    return r;
  endfunction

  assign full = (point_count == CNT_W'(MAX_POINTS));
  assign in_ready = (state == S_LOAD);
  assign in_acc = in_valid && in_ready;
  assign n_after = full ? point_count : point_count + 1'b1;
  // The first window of a pass starts HALF points before index zero, wrapped.
  assign start_after = ADDR_W'(n_after - CNT_W'(HALF));
  assign start_now = ADDR_W'(point_count - CNT_W'(HALF));
  assign ws_next = wrap_inc(win_start, point_count);

  assign mem_we = (in_acc && !full) || (state == S_DIV && dcnt == DIV_LAST);
  assign mem_waddr = (state == S_LOAD) ? point_count[ADDR_W-1:0] : pt_idx;
  assign mem_wdata = (state == S_LOAD) ? point_t'{x: point_x, y: point_y}
                                       : point_t'{x: res_x, y: div_q};
  assign mem_re = (state == S_READ) || (state == S_EMIT_RD);
  assign mem_raddr = (state == S_READ) ? rd_ptr : emit_idx;

  cps_store #(
    .DEPTH(MAX_POINTS),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // x enters the divider first and y follows in the next cycle.
  assign div_in = (dcnt == 3'd0) ? sum_x : sum_y;

  cps_rdiv #(
    .SPAN(SPAN),
    .SUM_W(SUM_W)
  ) u_rdiv (
    .clk(clk),
    .sum(div_in),
    .quot(div_q)
  );

  assign out_valid = (state == S_EMIT_OUT);
  assign smooth_x = mem_rdata.x;
  assign smooth_y = mem_rdata.y;
  assign last_out = (CNT_W'(emit_idx) + CNT_W'(1) == point_count);
  assign overflow = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      point_count <= '0;
      dropped <= 1'b0;
      passes <= PASSES_RESET;
      rd_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        passes <= cfg_data;
      end
      rd_vld <= (state == S_READ);
      // Read data lands in the cycle after its address, so accumulation trails the reads.
      if (rd_vld) begin
        sum_x <= sum_x + SUM_W'(mem_rdata.x);
        sum_y <= sum_y + SUM_W'(mem_rdata.y);
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              point_count <= point_count + 1'b1;
            end
            if (last_in) begin
              if (n_after >= CNT_W'(WINDOW) && passes != '0) begin
                state <= S_READ;
                pass_cnt <= '0;
                pt_idx <= '0;
                win_start <= start_after;
                rd_ptr <= start_after;
                tap <= '0;
                sum_x <= '0;
                sum_y <= '0;
              end else begin
                state <= S_EMIT_RD;
                emit_idx <= '0;
              end
            end
          end
        end
        S_READ: begin
          rd_ptr <= wrap_inc(rd_ptr, point_count);
          tap <= tap + 1'b1;
          if (tap == TAP_W'(SPAN - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DIV;
          dcnt <= '0;
        end
        S_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == 3'(DIV_LAT)) begin
            res_x <= div_q;
          end
          if (dcnt == DIV_LAST) begin
            tap <= '0;
            sum_x <= '0;
            sum_y <= '0;
            if (CNT_W'(pt_idx) + CNT_W'(1) == point_count) begin
              if (PASS_W'(pass_cnt + 1'b1) == passes) begin
                state <= S_EMIT_RD;
                emit_idx <= '0;
              end else begin
                state <= S_READ;
                pass_cnt <= pass_cnt + 1'b1;
                pt_idx <= '0;
                win_start <= start_now;
                rd_ptr <= start_now;
              end
            end else begin
              state <= S_READ;
              pt_idx <= pt_idx + 1'b1;
              win_start <= ws_next;
              rd_ptr <= ws_next;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_ready) begin
            if (last_out) begin
              state <= S_LOAD;
              point_count <= '0;
              dropped <= 1'b0;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_read_in_contour: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (CNT_W'(rd_ptr) < point_count))
    else $error("window read outside the loaded contour");

  a_emit_in_contour: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_W'(emit_idx) < point_count))
    else $error("emit index outside the loaded contour");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out) |=> (in_ready && point_count == '0))
    else $error("block did not return to loading after the last beat");

  a_drain_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_DIV && !rd_vld))
    else $error("window sum not complete when the divide starts");
`endif

endmodule
